>>> hdl/urfi_pkg.sv
// urfi_pkg: shared types, register offsets and constants of the uart register block
// used by urfi_rx_fifo and uart_register_model_rx_fifo_irq_core; no dependencies
package urfi_pkg;

  localparam int RX_DEPTH = 16;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);

  localparam int INT_W = 11;

  localparam logic [INT_W-1:0] INT_TX   = INT_W'(1 << 5);
  localparam logic [INT_W-1:0] INT_RX   = INT_W'(1 << 4);
  localparam logic [31:0]      PERIPH_ID = 32'h0014_1011;
  localparam logic [31:0]      CELL_ID   = 32'hB105_F00D;

  localparam logic [31:0] CTRL_RESET = 32'h0000_0300;
  localparam logic [31:0] IFLS_RESET = 32'h0000_0012;

  localparam logic [11:0] OFF_DATA  = 12'h000;
  localparam logic [11:0] OFF_RSR   = 12'h004;
  localparam logic [11:0] OFF_FLAG  = 12'h018;
  localparam logic [11:0] OFF_IBRD  = 12'h024;
  localparam logic [11:0] OFF_FBRD  = 12'h028;
  localparam logic [11:0] OFF_LCR   = 12'h02C;
  localparam logic [11:0] OFF_CTRL  = 12'h030;
  localparam logic [11:0] OFF_IFLS  = 12'h034;
  localparam logic [11:0] OFF_IMSC  = 12'h038;
  localparam logic [11:0] OFF_RIS   = 12'h03C;
  localparam logic [11:0] OFF_MIS   = 12'h040;
  localparam logic [11:0] OFF_ICR   = 12'h044;
  localparam logic [11:0] OFF_ID_LO = 12'hFE0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_st_t;

  // id registers hold one byte each, peripheral id first, low byte first
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [31:0] word;
    word = idx[2] ? CELL_ID : PERIPH_ID;
    return word[idx[1:0]*8 +: 8];
  endfunction

endpackage

>>> hdl/uart_register_model_rx_fifo_irq_core.sv
// uart_register_model_rx_fifo_irq_core: top level of the uart register block
// depends on urfi_pkg and urfi_rx_fifo
//
// usage: each input request is a bus read, a bus write or a received character
// (in_operation), with in_offset, in_write_data and in_rx_char as payload.
// every request produces exactly one result on the out_ channel: read data,
// decode hit, transmit character, interrupt level after the request and a
// drop flag for characters that found the receive fifo full.
// out_valid rises in the cycle after acceptance. throughput: one request
// per cycle while out_ready is high; registers and the fifo pointers update
// in the accept cycle, a data read pops the fifo store, whose registered read
// port supplies out_read_data in the result cycle.
// when the receiver stalls, the result is held and in_ready drops until it
// is taken; in_ready follows out_ready in the same cycle, so no bubble.
// reset (rst_n low, synchronous): fifo empty, interrupt status and mask
// clear, control word 0x300, fifo level select 0x12; store contents are
// left as they were and only written entries are ever read.
module uart_register_model_rx_fifo_irq_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_handled,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_char,
  output logic        out_irq_out,
  output logic        out_rx_dropped
);

  localparam int IW = urfi_pkg::INT_W;

  urfi_pkg::op_t       op;
  urfi_pkg::fifo_req_t fifo_req;
  urfi_pkg::fifo_st_t  fifo_st;
  logic [7:0]          fifo_rd;
  logic                accept;
  logic                is_id;

  logic          valid_r, valid_nxt;
  logic [IW-1:0] ists_r, ists_nxt;
  logic [IW-1:0] imsk_r, imsk_nxt;
  logic [15:0]   ibrd_r, ibrd_nxt;
  logic [5:0]    fbrd_r, fbrd_nxt;
  logic [7:0]    lcr_r, lcr_nxt;
  logic [31:0]   ctrl_r, ctrl_nxt;
  logic [31:0]   ifls_r, ifls_nxt;

  logic [31:0] rdata_r, rdata_nxt;
  logic        popsel_r, popsel_nxt;
  logic        handled_r, handled_nxt;
  logic        tx_r, tx_nxt;
  logic [7:0]  txch_r, txch_nxt;
  logic        irq_r, irq_nxt;
  logic        drop_r, drop_nxt;

  assign op       = urfi_pkg::op_t'(in_operation);
  assign in_ready = !valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_id    = (in_offset >= urfi_pkg::OFF_ID_LO) && (in_offset[1:0] == 2'b00);

  urfi_rx_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fifo_req),
    .st      (fifo_st),
    .rd_data (fifo_rd)
  );

  always_comb begin
    ists_nxt    = ists_r;
    imsk_nxt    = imsk_r;
    ibrd_nxt    = ibrd_r;
    fbrd_nxt    = fbrd_r;
    lcr_nxt     = lcr_r;
    ctrl_nxt    = ctrl_r;
    ifls_nxt    = ifls_r;
    rdata_nxt   = '0;
    popsel_nxt  = 1'b0;
    handled_nxt = 1'b0;
    tx_nxt      = 1'b0;
    txch_nxt    = '0;
    drop_nxt    = 1'b0;
    fifo_req    = '{push: 1'b0, pop: 1'b0, push_data: in_rx_char};
    if (accept) begin
      case (op)
        urfi_pkg::OP_READ: begin
          handled_nxt = 1'b1;
          if (is_id) begin
            rdata_nxt = {24'd0, urfi_pkg::id_byte(in_offset[4:2])};
          end else begin
            case (in_offset)
              urfi_pkg::OFF_DATA: begin
                if (!fifo_st.empty) begin
                  fifo_req.pop = 1'b1;
                  popsel_nxt   = 1'b1;
                  ists_nxt     = ists_r & ~urfi_pkg::INT_RX;
                end
              end
              urfi_pkg::OFF_RSR:  rdata_nxt = '0;
              urfi_pkg::OFF_FLAG: rdata_nxt = {24'd0, 1'b1, !lcr_r[4], 1'b0,
                                               fifo_st.empty, 4'd0};
              urfi_pkg::OFF_IBRD: rdata_nxt = {16'd0, ibrd_r};
              urfi_pkg::OFF_FBRD: rdata_nxt = {26'd0, fbrd_r};
              urfi_pkg::OFF_LCR:  rdata_nxt = {24'd0, lcr_r};
              urfi_pkg::OFF_CTRL: rdata_nxt = ctrl_r;
              urfi_pkg::OFF_IFLS: rdata_nxt = ifls_r;
              urfi_pkg::OFF_IMSC: rdata_nxt = {(32-IW)'(0), imsk_r};
              urfi_pkg::OFF_RIS:  rdata_nxt = {(32-IW)'(0), ists_r};
              urfi_pkg::OFF_MIS:  rdata_nxt = {(32-IW)'(0), ists_r & imsk_r};
              default:            handled_nxt = 1'b0;
            endcase
          end
        end
        urfi_pkg::OP_WRITE: begin
          handled_nxt = 1'b1;
          if (!is_id) begin
            case (in_offset)
              urfi_pkg::OFF_DATA: begin
                tx_nxt   = 1'b1;
                txch_nxt = in_write_data[7:0];
                ists_nxt = ists_r | urfi_pkg::INT_TX;
              end
              urfi_pkg::OFF_RSR:  ;
              urfi_pkg::OFF_FLAG: ;
              urfi_pkg::OFF_IBRD: ibrd_nxt = in_write_data[15:0];
              urfi_pkg::OFF_FBRD: fbrd_nxt = in_write_data[5:0];
              urfi_pkg::OFF_LCR:  lcr_nxt  = in_write_data[7:0];
              urfi_pkg::OFF_CTRL: ctrl_nxt = in_write_data;
              urfi_pkg::OFF_IFLS: ifls_nxt = in_write_data;
              urfi_pkg::OFF_IMSC: imsk_nxt = in_write_data[IW-1:0];
              urfi_pkg::OFF_ICR:  ists_nxt = ists_r & ~in_write_data[IW-1:0];
              default:            handled_nxt = 1'b0;
            endcase
          end
        end
        urfi_pkg::OP_RX: begin
          if (fifo_st.full) begin
            drop_nxt = 1'b1;
          end else begin
            fifo_req.push = 1'b1;
            ists_nxt      = ists_r | urfi_pkg::INT_RX;
          end
        end
        default: ;
      endcase
    end
    // interrupt level after this request
    irq_nxt = |(ists_nxt & imsk_nxt);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ists_r  <= '0;
      imsk_r  <= '0;
      ibrd_r  <= '0;
      fbrd_r  <= '0;
      lcr_r   <= '0;
      ctrl_r  <= urfi_pkg::CTRL_RESET;
      ifls_r  <= urfi_pkg::IFLS_RESET;
    end else begin
      valid_r <= valid_nxt;
      ists_r  <= ists_nxt;
      imsk_r  <= imsk_nxt;
      ibrd_r  <= ibrd_nxt;
      fbrd_r  <= fbrd_nxt;
      lcr_r   <= lcr_nxt;
      ctrl_r  <= ctrl_nxt;
      ifls_r  <= ifls_nxt;
    end
  end

  // result payload only loads on an accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r   <= rdata_nxt;
      popsel_r  <= popsel_nxt;
      handled_r <= handled_nxt;
      tx_r      <= tx_nxt;
      txch_r    <= txch_nxt;
      irq_r     <= irq_nxt;
      drop_r    <= drop_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_read_data  = popsel_r ? {24'd0, fifo_rd} : rdata_r;
  assign out_handled    = handled_r;
  assign out_tx_valid   = tx_r;
  assign out_tx_char    = txch_r;
  assign out_irq_out    = irq_r;
  assign out_rx_dropped = drop_r;

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted over a stalled result");
  a_irq_level: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_irq_out == |(ists_r & imsk_r))
    else $error("irq level differs from masked status");
  a_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tx_valid && out_rx_dropped) && !(popsel_r && out_tx_valid))
    else $error("conflicting result flags");
`endif

endmodule

>>> hdl/urfi_rx_fifo.sv
// urfi_rx_fifo: receive fifo with head pointer, fill count and a synchronous store
// depends on urfi_pkg for depth, widths and the request/status structs
module urfi_rx_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  urfi_pkg::fifo_req_t  req,
  output urfi_pkg::fifo_st_t   st,
  output logic [7:0]           rd_data
);

  localparam int AW = urfi_pkg::RX_AW;
  localparam int CW = urfi_pkg::RX_CW;

  logic [7:0]    mem [urfi_pkg::RX_DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   wsum;
  logic [AW-1:0] waddr;

  assign st.empty = (count_r == '0);
  assign st.full  = (count_r == CW'(urfi_pkg::RX_DEPTH));

  // tail = (head + count) mod depth, sum stays below twice the depth
  always_comb begin
    wsum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (wsum >= (CW+1)'(urfi_pkg::RX_DEPTH)) begin
      wsum = wsum - (CW+1)'(urfi_pkg::RX_DEPTH);
    end
    waddr = wsum[AW-1:0];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (req.pop) begin
      head_nxt  = (head_r == AW'(urfi_pkg::RX_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (req.push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[waddr] <= req.push_data;
    end
    if (req.pop) begin
      rd_data <= mem[head_r];
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(urfi_pkg::RX_DEPTH))
    else $error("rx fifo count above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> !st.full)
    else $error("push into full rx fifo");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req.pop |-> !st.empty)
    else $error("pop from empty rx fifo");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (req.push && !req.pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("rx fifo count did not advance on push");
`endif

endmodule

>>> dv/tb.sv
// tb: self-checking bench for uart_register_model_rx_fifo_irq_core, covering register
// decode, receive fifo, transmit path and interrupt level, with random traffic and stalls
// depends on urfi_pkg and the block's rtl
module tb;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          EXP_DEPTH    = 8;
  localparam logic [11:0] OFF_HOLE_020 = 12'h020;
  localparam logic [11:0] OFF_HOLE_048 = 12'h048;

  typedef struct packed {
    logic [31:0] read_data;
    logic        handled;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic        irq_out;
    logic        rx_dropped;
  } access_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [11:0] in_offset;
  logic [31:0] in_write_data;
  logic [7:0]  in_rx_char;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        out_handled;
  logic        out_tx_valid;
  logic [7:0]  out_tx_char;
  logic        out_irq_out;
  logic        out_rx_dropped;

  // model copy of the register block
  logic [7:0]                 rx_mem [urfi_pkg::RX_DEPTH];
  logic [urfi_pkg::RX_AW-1:0] rx_rd_ptr;
  logic [urfi_pkg::RX_CW-1:0] rx_level;
  logic [urfi_pkg::INT_W-1:0] status_bits;
  logic [urfi_pkg::INT_W-1:0] mask_bits;
  logic [15:0]                baud_int_q;
  logic [5:0]                 baud_frac_q;
  logic [7:0]                 lcr_q;
  logic [31:0]                ctrl_q;
  logic [31:0]                ifls_q;

  // expected results in request order
  access_result_t exp_store [EXP_DEPTH];
  int unsigned    exp_wr;
  int unsigned    exp_rd;
  int unsigned    exp_cnt;

  int unsigned    err_cnt;
  int unsigned    sent_cnt;
  int             burst_left;
  bit             steady_flow;
  int             hold_left;

  uart_register_model_rx_fifo_irq_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_offset      (in_offset),
    .in_write_data  (in_write_data),
    .in_rx_char     (in_rx_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_handled    (out_handled),
    .out_tx_valid   (out_tx_valid),
    .out_tx_char    (out_tx_char),
    .out_irq_out    (out_irq_out),
    .out_rx_dropped (out_rx_dropped)
  );

  always #5 clk = ~clk;

  function automatic bit is_id_offset(input logic [11:0] off);
    return (off >= urfi_pkg::OFF_ID_LO) && (off[1:0] == 2'b00);
  endfunction

  task automatic uart_reset_state();
    rx_rd_ptr   = '0;
    rx_level    = '0;
    status_bits = '0;
    mask_bits   = '0;
    baud_int_q  = '0;
    baud_frac_q = '0;
    lcr_q       = '0;
    ctrl_q      = urfi_pkg::CTRL_RESET;
    ifls_q      = urfi_pkg::IFLS_RESET;
  endtask

  // applies one request to the model state and returns its result
  task automatic uart_access(input urfi_pkg::op_t op, input logic [11:0] off,
                             input logic [31:0] wdata, input logic [7:0] ch,
                             output access_result_t r);
    int unsigned id_idx;
    logic [31:0] id_word;
    r = '0;
    case (op)
      urfi_pkg::OP_READ: begin
        r.handled = 1'b1;
        if (is_id_offset(off)) begin
          id_idx = (off - urfi_pkg::OFF_ID_LO) >> 2;
          id_word = (id_idx < 4) ? urfi_pkg::PERIPH_ID : urfi_pkg::CELL_ID;
          r.read_data = (id_word >> ((id_idx % 4) * 8)) & 32'hFF;
        end else begin
          case (off)
            urfi_pkg::OFF_DATA: begin
              if (rx_level != 0) begin
                r.read_data = 32'(rx_mem[rx_rd_ptr]);
                rx_rd_ptr = urfi_pkg::RX_AW'((rx_rd_ptr + 1) % urfi_pkg::RX_DEPTH);
                rx_level = rx_level - 1'b1;
                status_bits &= ~urfi_pkg::INT_RX;
              end
            end
            urfi_pkg::OFF_RSR:  r.read_data = '0;
            urfi_pkg::OFF_FLAG: r.read_data = {24'b0, 1'b1, ~lcr_q[4], 1'b0, rx_level == 0,
                                               4'b0};
            urfi_pkg::OFF_IBRD: r.read_data = 32'(baud_int_q);
            urfi_pkg::OFF_FBRD: r.read_data = 32'(baud_frac_q);
            urfi_pkg::OFF_LCR:  r.read_data = 32'(lcr_q);
            urfi_pkg::OFF_CTRL: r.read_data = ctrl_q;
            urfi_pkg::OFF_IFLS: r.read_data = ifls_q;
            urfi_pkg::OFF_IMSC: r.read_data = 32'(mask_bits);
            urfi_pkg::OFF_RIS:  r.read_data = 32'(status_bits);
            urfi_pkg::OFF_MIS:  r.read_data = 32'(status_bits & mask_bits);
            default:            r.handled = 1'b0;
          endcase
        end
      end
      urfi_pkg::OP_WRITE: begin
        r.handled = 1'b1;
        // id registers are read-only but still decoded
        if (!is_id_offset(off)) begin
          case (off)
            urfi_pkg::OFF_DATA: begin
              r.tx_valid = 1'b1;
              r.tx_char = wdata[7:0];
              status_bits |= urfi_pkg::INT_TX;
            end
            urfi_pkg::OFF_RSR, urfi_pkg::OFF_FLAG: ;
            urfi_pkg::OFF_IBRD: baud_int_q = wdata[15:0];
            urfi_pkg::OFF_FBRD: baud_frac_q = wdata[5:0];
            urfi_pkg::OFF_LCR:  lcr_q = wdata[7:0];
            urfi_pkg::OFF_CTRL: ctrl_q = wdata;
            urfi_pkg::OFF_IFLS: ifls_q = wdata;
            urfi_pkg::OFF_IMSC: mask_bits = wdata[urfi_pkg::INT_W-1:0];
            urfi_pkg::OFF_ICR:  status_bits &= ~wdata[urfi_pkg::INT_W-1:0];
            default:            r.handled = 1'b0;
          endcase
        end
      end
      urfi_pkg::OP_RX: begin
        if (rx_level >= urfi_pkg::RX_DEPTH) begin
          r.rx_dropped = 1'b1;
        end else begin
          rx_mem[urfi_pkg::RX_AW'((rx_rd_ptr + rx_level) % urfi_pkg::RX_DEPTH)] = ch;
          rx_level = rx_level + 1'b1;
          status_bits |= urfi_pkg::INT_RX;
        end
      end
      default: ;
    endcase
    r.irq_out = |(status_bits & mask_bits);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // results are checked before the request of the same edge enters the model
  always @(posedge clk) begin : result_check
    access_result_t want, req_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_cnt == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual read_data %0h",
                   $time, out_read_data);
        end else begin
          want = exp_store[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_cnt--;
          compare_field("read_data", want.read_data, out_read_data);
          compare_field("handled", 32'(want.handled), 32'(out_handled));
          compare_field("tx_valid", 32'(want.tx_valid), 32'(out_tx_valid));
          compare_field("tx_char", 32'(want.tx_char), 32'(out_tx_char));
          compare_field("irq_out", 32'(want.irq_out), 32'(out_irq_out));
          compare_field("rx_dropped", 32'(want.rx_dropped), 32'(out_rx_dropped));
        end
      end
      if (in_valid && in_ready) begin
        uart_access(urfi_pkg::op_t'(in_operation), in_offset, in_write_data, in_rx_char,
                    req_res);
        exp_store[exp_wr] = req_res;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_cnt++;
      end
    end
  end

  // receiver: random stall patterns, plus long hold-offs on request
  initial begin : receiver
    int unsigned mode;
    int unsigned phase;
    out_ready = 1'b0;
    mode = 0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (phase == 0) begin
          mode = $urandom_range(0, 3);
          phase = $urandom_range(16, 96);
        end
        phase--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (phase % 3 != 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // offers one request and waits for its handshake; idles between bursts unless steady_flow is set
  task automatic send_req(input urfi_pkg::op_t op, input logic [11:0] off,
                          input logic [31:0] wdata, input logic [7:0] ch);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_offset     <= off;
    in_write_data <= wdata;
    in_rx_char    <= ch;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (!steady_flow) begin
      burst_left--;
      if (burst_left <= 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_reg_offset();
    case ($urandom_range(0, 12))
      0:       return urfi_pkg::OFF_DATA;
      1:       return urfi_pkg::OFF_RSR;
      2:       return urfi_pkg::OFF_FLAG;
      3:       return urfi_pkg::OFF_IBRD;
      4:       return urfi_pkg::OFF_FBRD;
      5:       return urfi_pkg::OFF_LCR;
      6:       return urfi_pkg::OFF_CTRL;
      7:       return urfi_pkg::OFF_IFLS;
      8:       return urfi_pkg::OFF_IMSC;
      9:       return urfi_pkg::OFF_RIS;
      10:      return urfi_pkg::OFF_MIS;
      11:      return urfi_pkg::OFF_ICR;
      default: return urfi_pkg::OFF_ID_LO + 12'(4 * $urandom_range(0, 7));
    endcase
  endfunction

  task automatic test_register_defaults_and_extremes();
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_FLAG, '0, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_CTRL, '0, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_IFLS, '0, '0);
    // pop with the fifo empty
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_DATA, '0, '0);
    send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_IBRD, '1, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_IBRD, '0, '0);
    send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_FBRD, '1, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_FBRD, '0, '0);
    send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_LCR,  '1, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_FLAG, '0, '0);
    send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_IMSC, '1, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_IMSC, '0, '0);
    send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_DATA, '1, '0);
    send_req(urfi_pkg::OP_RX,    12'hFFF,  '1, 8'h00);
    send_req(urfi_pkg::OP_RX,    '0,       '0, 8'hFF);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_RIS,  '0, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_MIS,  '0, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_DATA, '0, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_DATA, '0, '0);
    send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_ICR,  '1, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_ID_LO, '0, '0);
    send_req(urfi_pkg::OP_READ,  12'hFFC,  '0, '0);
    // unaligned id offset and holes in the map are not decoded
    send_req(urfi_pkg::OP_READ,  12'hFE1,  '0, '0);
    send_req(urfi_pkg::OP_WRITE, 12'hFFC,  '1, '0);
    send_req(urfi_pkg::OP_READ,  urfi_pkg::OFF_ICR,  '0, '0);
    send_req(urfi_pkg::OP_WRITE, OFF_HOLE_048, '1, '0);
    send_req(urfi_pkg::OP_READ,  OFF_HOLE_020, '0, '0);
    send_req(urfi_pkg::OP_NONE,  12'hFFF,  '1, 8'hFF);
  endtask

  task automatic test_fifo_overflow();
    repeat (urfi_pkg::RX_DEPTH + 1)
      send_req(urfi_pkg::OP_RX, 12'($urandom), rand_word(), 8'($urandom));
    send_req(urfi_pkg::OP_READ, urfi_pkg::OFF_FLAG, '0, '0);
    repeat (urfi_pkg::RX_DEPTH + 1)
      send_req(urfi_pkg::OP_READ, urfi_pkg::OFF_DATA, rand_word(), 8'($urandom));
    send_req(urfi_pkg::OP_READ, urfi_pkg::OFF_FLAG, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    logic [11:0] off;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      len = $urandom_range(1, 12);
      steady_flow = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 20))
                send_req(urfi_pkg::OP_RX, 12'($urandom), rand_word(), 8'($urandom));
        2, 3: repeat ($urandom_range(1, 18))
                send_req(urfi_pkg::OP_READ, urfi_pkg::OFF_DATA, rand_word(), 8'($urandom));
        4: begin
          off = pick_reg_offset();
          send_req(urfi_pkg::OP_WRITE, off, rand_word(), 8'($urandom));
          send_req(urfi_pkg::OP_READ, off, rand_word(), 8'($urandom));
        end
        5: begin
          send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_IMSC, rand_word(), 8'($urandom));
          if ($urandom_range(0, 1))
            send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_DATA, rand_word(), 8'($urandom));
          else
            send_req(urfi_pkg::OP_RX, 12'($urandom), rand_word(), 8'($urandom));
          send_req(urfi_pkg::OP_READ, urfi_pkg::OFF_MIS, rand_word(), 8'($urandom));
          send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_ICR, rand_word(), 8'($urandom));
          send_req(urfi_pkg::OP_READ, urfi_pkg::OFF_RIS, rand_word(), 8'($urandom));
        end
        6: repeat (len)
             send_req(urfi_pkg::OP_WRITE, urfi_pkg::OFF_DATA, rand_word(), 8'($urandom));
        7: repeat (len)
             send_req(urfi_pkg::op_t'($urandom_range(0, 1)),
                      urfi_pkg::OFF_ID_LO + 12'($urandom_range(0, 31)),
                      rand_word(), 8'($urandom));
        8: repeat (len) begin
          off = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 'h50));
          send_req(urfi_pkg::op_t'($urandom_range(0, 3)), off, $urandom, 8'($urandom));
        end
        default: repeat (len)
                   send_req(urfi_pkg::OP_READ, pick_reg_offset(), rand_word(), 8'($urandom));
      endcase
    end
    steady_flow = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_receiver_holdoff();
    while (hold_left != 0) @(posedge clk);
    hold_left = HOLD_CYCLES;
    steady_flow = 1'b1;
    repeat (12) send_req(urfi_pkg::OP_RX, 12'($urandom), rand_word(), 8'($urandom));
    repeat (12) send_req(urfi_pkg::op_t'($urandom_range(0, 1)), pick_reg_offset(),
                         rand_word(), 8'($urandom));
    steady_flow = 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = urfi_pkg::OP_NONE;
    in_offset     = '0;
    in_write_data = '0;
    in_rx_char    = '0;
    err_cnt       = 0;
    sent_cnt      = 0;
    exp_wr        = 0;
    exp_rd        = 0;
    exp_cnt       = 0;
    steady_flow   = 1'b0;
    hold_left     = 0;
    burst_left    = $urandom_range(1, 16);
    uart_reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults_and_extremes();
    test_fifo_overflow();
    test_random_traffic(200);
    test_receiver_holdoff();
    test_random_traffic(200);
    test_receiver_holdoff();
    test_random_traffic(80);

    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> uart_register_model_rx_fifo_irq_core.f
hdl/urfi_pkg.sv
hdl/urfi_rx_fifo.sv
hdl/uart_register_model_rx_fifo_irq_core.sv
dv/tb.sv
